/* src/glr_pkg.sv */
// ----------------------------------------------------------------------------
// glr_pkg: shared constants and helpers for the gradient line rasterizer
// Field widths, screen geometry and the coordinate wrap function.
// ----------------------------------------------------------------------------
package glr_pkg;

  localparam int COORD_W             = 6;   // endpoint and pixel coordinate width
  localparam int DELTA_W             = 7;   // signed endpoint difference
  localparam int COLOR_W             = 8;   // one colour channel
  localparam int STEP_W              = 9;   // signed per-channel colour step
  localparam int LEN_W               = 7;   // floor of the line length
  localparam int D2_W                = 13;  // squared distance, up to 2 * 63^2
  localparam int NUM_CH              = 3;
  localparam int SCREEN_WIDTH        = 64;
  localparam int SCREEN_HEIGHT       = 64;
  localparam int DIST_FRAC_BITS_DEF  = 8;

  // negative coordinate gets the screen size added once, then kept to 6 bits
  function automatic logic [COORD_W-1:0] wrap_coord(input logic signed [DELTA_W-1:0] c,
                                                    input int size);
    logic [DELTA_W:0] s;
    s = {c[DELTA_W-1], c};
    if (c[DELTA_W-1]) s = s + (DELTA_W+1)'(size);
    return s[COORD_W-1:0];
  endfunction

endpackage

/* src/gradient_line_rasterizer_top.sv */
// ----------------------------------------------------------------------------
// gradient_line_rasterizer_top: line walker with a linear colour ramp
// Walks the major axis one pixel at a time, shading each pixel by distance.
// ----------------------------------------------------------------------------
// One line request is taken while the block is idle; in_stall stays high until
// the final pixel has gone into the output register. The square root unit gives
// R = DIST_FRAC_BITS+7 root bits, one bit per cycle. Setup squares dx and dy on
// the shared multiplier, takes the root as the line length, then runs the three
// 8-step colour divisions when the line length is not zero. After every pixel but
// the last the next one is computed (two squares on the shared multiplier, the
// square root, three shading multiplies); each pixel waits while the output is
// stalled.
module gradient_line_rasterizer_top #(
  parameter int DIST_FRAC_BITS = glr_pkg::DIST_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [glr_pkg::COORD_W-1:0]   x_start,
  input  logic signed [glr_pkg::COORD_W-1:0]   y_start,
  input  logic signed [glr_pkg::COORD_W-1:0]   x_end,
  input  logic signed [glr_pkg::COORD_W-1:0]   y_end,
  input  logic        [glr_pkg::COLOR_W-1:0]   red_start,
  input  logic        [glr_pkg::COLOR_W-1:0]   green_start,
  input  logic        [glr_pkg::COLOR_W-1:0]   blue_start,
  input  logic        [glr_pkg::COLOR_W-1:0]   red_end,
  input  logic        [glr_pkg::COLOR_W-1:0]   green_end,
  input  logic        [glr_pkg::COLOR_W-1:0]   blue_end,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic        [glr_pkg::COORD_W-1:0]   pixel_x,
  output logic        [glr_pkg::COORD_W-1:0]   pixel_y,
  output logic        [glr_pkg::COLOR_W-1:0]   red,
  output logic        [glr_pkg::COLOR_W-1:0]   green,
  output logic        [glr_pkg::COLOR_W-1:0]   blue,
  output logic                                 last
);
  import glr_pkg::*;

  localparam int RW    = DIST_FRAC_BITS + 7;   // root bits of the distance
  localparam int NW    = 2 * RW;               // radicand bits
  localparam int PW    = STEP_W + RW + 1;      // multiplier product
  localparam int SW    = PW + 1;               // shading sum
  localparam int CNT_W = $clog2(RW);
  localparam int MAJ_W = COORD_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ_X, S_SQ_Y, S_SQ_SUM, S_SQRT, S_DIV_LOAD, S_DIV, S_EMIT, S_SHADE
  } state_t;

  state_t                     state;
  logic                       setup;
  logic signed [DELTA_W-1:0]  x0, y0, dx, dy, x, y;
  logic                       x_major, maj_neg, min_neg;
  logic        [MAJ_W-1:0]    major, minor, acc, k;
  logic        [COLOR_W-1:0]  c0   [NUM_CH];
  logic        [COLOR_W-1:0]  c1   [NUM_CH];
  logic        [COLOR_W-1:0]  col  [NUM_CH];
  logic signed [STEP_W-1:0]   step [NUM_CH];
  logic signed [PW-1:0]       mul_q;
  logic        [D2_W-1:0]     d2;
  logic        [NW-1:0]       rad;
  logic        [RW+1:0]       rem;
  logic        [RW-1:0]       root;
  logic        [CNT_W-1:0]    cnt;
  logic        [1:0]          ch;
  logic        [COLOR_W-1:0]  num, quo;
  logic        [COLOR_W:0]    drem;
  logic                       dneg;
  logic        [2:0]          dcnt;

  // request decode
  logic signed [DELTA_W-1:0]  in_dx, in_dy;
  logic        [MAJ_W-1:0]    in_adx, in_ady;
  logic                       in_xfer, out_free;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign in_dx  = DELTA_W'({x_end[COORD_W-1], x_end}) - DELTA_W'({x_start[COORD_W-1], x_start});
  assign in_dy  = DELTA_W'({y_end[COORD_W-1], y_end}) - DELTA_W'({y_start[COORD_W-1], y_start});
  assign in_adx = in_dx[DELTA_W-1] ? MAJ_W'(-in_dx) : MAJ_W'(in_dx);
  assign in_ady = in_dy[DELTA_W-1] ? MAJ_W'(-in_dy) : MAJ_W'(in_dy);

  // shared multiplier: squares of the offsets, then step times distance
  logic signed [DELTA_W-1:0]  ex, ey, eop;
  logic signed [STEP_W-1:0]   mul_a, step_sel;
  logic signed [RW:0]         mul_b;
  logic signed [PW-1:0]       mul_p;

  assign ex  = setup ? dx : DELTA_W'(x - x0);
  assign ey  = setup ? dy : DELTA_W'(y - y0);
  assign eop = (state == S_SQ_Y) ? ey : ex;

  always_comb begin
    case (ch)
      2'd0:    step_sel = step[0];
      2'd1:    step_sel = step[1];
      default: step_sel = step[2];
    endcase
  end

  always_comb begin
    if (state == S_SHADE) begin
      mul_a = step_sel;
      mul_b = $signed({1'b0, root});
    end else begin
      mul_a = STEP_W'(eop);
      mul_b = (RW+1)'(eop);
    end
  end

  assign mul_p = mul_a * mul_b;

  // square root, one root bit per cycle
  logic [RW+1:0] rem_sh, trial;
  logic          sq_ge;
  logic [RW-1:0] root_next;

  assign rem_sh    = {rem[RW-1:0], rad[NW-1 -: 2]};
  assign trial     = {root, 2'b01};
  assign sq_ge     = rem_sh >= trial;
  assign root_next = {root[RW-2:0], sq_ge};

  logic [D2_W-1:0] d2_sum;
  assign d2_sum = d2 + mul_q[D2_W-1:0];

  // colour step division, one quotient bit per cycle
  logic [COLOR_W-1:0]        c0_sel, c1_sel;
  logic signed [COLOR_W:0]   diff;
  logic [COLOR_W:0]          drem_sh, len9;
  logic                      dge;
  logic [COLOR_W-1:0]        quo_next;

  always_comb begin
    case (ch)
      2'd0:    begin c0_sel = c0[0]; c1_sel = c1[0]; end
      2'd1:    begin c0_sel = c0[1]; c1_sel = c1[1]; end
      default: begin c0_sel = c0[2]; c1_sel = c1[2]; end
    endcase
  end

  assign diff     = $signed({1'b0, c1_sel}) - $signed({1'b0, c0_sel});
  assign drem_sh  = {drem[COLOR_W-1:0], num[COLOR_W-1]};
  assign len9     = (COLOR_W+1)'(root[LEN_W-1:0]);
  assign dge      = drem_sh >= len9;
  assign quo_next = {quo[COLOR_W-2:0], dge};

  // shading of the channel whose product sits in mul_q
  logic [COLOR_W-1:0]  c0_prev, col_new;
  logic signed [SW-1:0] shade_sum, shade_shr;

  always_comb begin
    case (ch)
      2'd1:    c0_prev = c0[0];
      2'd2:    c0_prev = c0[1];
      default: c0_prev = c0[2];
    endcase
  end

  assign shade_sum = ($signed(SW'({1'b0, c0_prev})) <<< DIST_FRAC_BITS) + SW'(mul_q);
  assign shade_shr = shade_sum >>> DIST_FRAC_BITS;
  assign col_new   = shade_sum[SW-1] ? '0 :
                     (shade_shr > $signed(SW'(255))) ? '1 : shade_shr[COLOR_W-1:0];

  // minor axis error accumulator
  logic [MAJ_W:0] acc_sum;
  logic           acc_hit;
  assign acc_sum = {1'b0, acc} + {1'b0, minor};
  assign acc_hit = acc_sum >= {1'b0, major};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      setup     <= 1'b0;
      ch        <= '0;
      cnt       <= '0;
      dcnt      <= '0;
      k         <= '0;
      acc       <= '0;
      major     <= '0;
    end else begin
      if (state == S_EMIT && out_free) out_valid <= 1'b1;
      else if (!out_stall)             out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            x0      <= DELTA_W'({x_start[COORD_W-1], x_start});
            y0      <= DELTA_W'({y_start[COORD_W-1], y_start});
            x       <= DELTA_W'({x_start[COORD_W-1], x_start});
            y       <= DELTA_W'({y_start[COORD_W-1], y_start});
            dx      <= in_dx;
            dy      <= in_dy;
            x_major <= in_adx >= in_ady;
            if (in_adx >= in_ady) begin
              major   <= in_adx;
              minor   <= in_ady;
              maj_neg <= in_dx[DELTA_W-1];
              min_neg <= in_dy[DELTA_W-1];
            end else begin
              major   <= in_ady;
              minor   <= in_adx;
              maj_neg <= in_dy[DELTA_W-1];
              min_neg <= in_dx[DELTA_W-1];
            end
            acc     <= '0;
            k       <= '0;
            ch      <= '0;
            c0[0]   <= red_start;
            c0[1]   <= green_start;
            c0[2]   <= blue_start;
            c1[0]   <= red_end;
            c1[1]   <= green_end;
            c1[2]   <= blue_end;
            col[0]  <= red_start;
            col[1]  <= green_start;
            col[2]  <= blue_start;
            step[0] <= '0;
            step[1] <= '0;
            step[2] <= '0;
            setup   <= 1'b1;
            state   <= S_SQ_X;
          end
        end
        S_SQ_X: begin
          mul_q <= mul_p;
          state <= S_SQ_Y;
        end
        S_SQ_Y: begin
          d2    <= mul_q[D2_W-1:0];
          mul_q <= mul_p;
          state <= S_SQ_SUM;
        end
        S_SQ_SUM: begin
          if (setup) rad <= NW'(d2_sum);
          else       rad <= NW'(d2_sum) << (2 * DIST_FRAC_BITS);
          rem   <= '0;
          root  <= '0;
          cnt   <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          rad  <= rad << 2;
          rem  <= sq_ge ? (rem_sh - trial) : rem_sh;
          root <= root_next;
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_W'(RW - 1)) begin
            ch <= '0;
            if (!setup)                          state <= S_SHADE;
            else if (root_next[LEN_W-1:0] == '0) state <= S_EMIT;
            else                                 state <= S_DIV_LOAD;
          end
        end
        S_DIV_LOAD: begin
          num   <= diff[COLOR_W] ? COLOR_W'(-diff) : diff[COLOR_W-1:0];
          dneg  <= diff[COLOR_W];
          drem  <= '0;
          quo   <= '0;
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          num  <= num << 1;
          drem <= dge ? (drem_sh - len9) : drem_sh;
          quo  <= quo_next;
          dcnt <= dcnt + 1'b1;
          if (dcnt == 3'd7) begin
            step[ch] <= dneg ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
            if (ch == 2'd2) begin
              state <= S_EMIT;
            end else begin
              ch    <= ch + 1'b1;
              state <= S_DIV_LOAD;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            pixel_x   <= wrap_coord(x, SCREEN_WIDTH);
            pixel_y   <= wrap_coord(y, SCREEN_HEIGHT);
            red       <= col[0];
            green     <= col[1];
            blue      <= col[2];
            last      <= (k == major);
            if (k == major) begin
              state <= S_IDLE;
            end else begin
              setup <= 1'b0;
              state <= S_SQ_X;
            end
          end
        end
        S_SHADE: begin
          // multiply for channel ch while channel ch-1 is clamped
          if (ch != 2'd3) mul_q <= mul_p;
          if (ch != 2'd0) col[ch - 2'd1] <= col_new;
          if (ch == 2'd3) begin
            if (acc_hit) begin
              acc <= MAJ_W'(acc_sum - {1'b0, major});
              if (x_major) y <= y + (min_neg ? -7'sd1 : 7'sd1);
              else         x <= x + (min_neg ? -7'sd1 : 7'sd1);
            end else begin
              acc <= acc_sum[MAJ_W-1:0];
            end
            if (x_major) x <= x + (maj_neg ? -7'sd1 : 7'sd1);
            else         y <= y + (maj_neg ? -7'sd1 : 7'sd1);
            k     <= k + 1'b1;
            state <= S_EMIT;
          end else begin
            ch <= ch + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> in_stall)
    else $error("block took a request but did not go busy");

  a_acc_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (acc < major || acc == '0))
    else $error("error accumulator out of range");

  a_pixel_count: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (k <= major))
    else $error("pixel counter ran past the major length");

  a_sqrt_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT) |-> (cnt <= CNT_W'(RW - 1)))
    else $error("square root iteration count overrun");

  a_last_then_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free && k == major) |=> (state == S_IDLE && out_valid && last))
    else $error("final pixel transfer did not end the line");

endmodule
